@@ hw/rtl/port_power_priority_arbiter_top_defines.svh @@
// Assertion macros shared by the arbiter RTL.
`ifndef PORT_POWER_PRIORITY_ARBITER_TOP_DEFINES_SVH
`define PORT_POWER_PRIORITY_ARBITER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PPPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPPA_ASSERT(lbl, prop, msg)
`define PPPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/pppa_pkg.sv @@
// Types and constants of the port power priority arbiter.
package pppa_pkg;

  localparam logic       OP_POWER   = 1'b0;
  localparam logic       OP_REINIT  = 1'b1;

  localparam logic [1:0] SW_DONE    = 2'd0;
  localparam logic [1:0] SW_REFUSED = 2'd1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_PORT   = 3'd1;
  localparam logic [2:0] ST_LOWER_PERM = 3'd2;
  localparam logic [2:0] ST_OVER_MAX   = 3'd3;
  localparam logic [2:0] ST_SW_FAILED  = 3'd4;

  localparam logic [2:0] PRIO_LOWEST  = 3'd0;
  localparam logic [2:0] PRIO_HIGHEST = 3'd7;
  localparam logic [5:0] COUNT_MAX    = 6'd63;
  localparam logic [5:0] MAX_OPEN_RESET = 6'd32;

  localparam logic REG_MAX_OPEN = 1'b0;

  typedef struct packed {
    logic       opcode;
    logic [5:0] port_index;
    logic       want_open;
    logic [2:0] requester_priority;
    logic [1:0] switch_outcome;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       actuate;
    logic       port_is_open;
    logic [2:0] owner_priority;
    logic [5:0] open_count;
  } rsp_t;

  // One entry of the per-port table.
  typedef struct packed {
    logic       is_open;
    logic [2:0] prio;
  } ent_t;

endpackage

@@ hw/rtl/port_power_priority_arbiter_top.sv @@
// Top level of the port power priority arbiter.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   pppa_pkg::req_t
//   rsp       out        rsp_valid/rsp_stall   pppa_pkg::rsp_t
//   apb       in/out     psel/penable/pready   max_open_ports at address 0
//
// Each request first has the port's entry read from the table RAM, then
// it is decided: the entry is written back and the result register loaded.
// Reset clears the port valid bits, the open count and the control state;
// a port whose valid bit is clear reads as closed with the lowest priority.
// A result waiting in the output register does not block the next request
// from being read; only the decide cycle waits while a held result is stalled.
`include "port_power_priority_arbiter_top_defines.svh"

module port_power_priority_arbiter_top #(
  parameter int NUM_PORTS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pppa_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pppa_pkg::rsp_t  rsp_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                 st;
  pppa_pkg::req_t         item;
  logic [5:0]             open_cnt;
  logic [5:0]             max_open;
  logic [NUM_PORTS-1:0]   ent_valid;

  logic                   req_acc;
  logic                   load;
  logic                   ram_we;
  logic [AW-1:0]          waddr;
  logic [3:0]             ram_rdata;
  pppa_pkg::ent_t         ent_rd;
  pppa_pkg::ent_t         ent_new;
  logic                   wr;
  logic                   in_range;
  logic [2:0]             owner;
  logic                   is_open;
  logic [2:0]             status;
  logic                   act;
  logic [5:0]             cnt_next;

  // Configuration port: one register, index taken from the word address bit.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_open <= pppa_pkg::MAX_OPEN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == pppa_pkg::REG_MAX_OPEN)) begin
      max_open <= pwdata[5:0];
    end
  end
  assign prdata = (paddr[2] == pppa_pkg::REG_MAX_OPEN) ? {26'd0, max_open} : 32'd0;

  // Requests are taken only when no item is being decided.
  assign req_stall = (st != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign load      = (st == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign waddr  = item.port_index[AW-1:0];
  assign ram_we = load && wr;

  pppa_ram #(
    .WIDTH ($bits(pppa_pkg::ent_t)),
    .DEPTH (NUM_PORTS)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ent_new),
    .re    (req_acc),
    .raddr (req_data.port_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent_rd = pppa_pkg::ent_t'(ram_rdata);

  // Decide logic. An entry never written since reset reads as closed and
  // lowest priority. The write into the table happens in the decide cycle,
  // and the next read is issued no earlier than the following cycle, so no
  // forwarding is needed.
  always_comb begin
    in_range = (item.port_index < 6'(NUM_PORTS));
    owner    = (in_range && ent_valid[waddr]) ? ent_rd.prio : pppa_pkg::PRIO_LOWEST;
    is_open  = in_range && ent_valid[waddr] && ent_rd.is_open;
    status   = pppa_pkg::ST_OK;
    act      = 1'b0;
    wr       = 1'b0;
    ent_new.is_open = is_open;
    ent_new.prio    = owner;
    cnt_next = open_cnt;
    if (!in_range) begin
      status          = pppa_pkg::ST_BAD_PORT;
      ent_new.is_open = 1'b0;
      ent_new.prio    = pppa_pkg::PRIO_LOWEST;
    end else if (item.opcode == pppa_pkg::OP_REINIT) begin
      wr              = 1'b1;
      ent_new.is_open = 1'b0;
      ent_new.prio    = pppa_pkg::PRIO_LOWEST;
      cnt_next        = (open_cnt != 6'd0) ? open_cnt - 6'd1 : open_cnt;
    end else if ((item.want_open || is_open) && (item.requester_priority < owner)) begin
      status = pppa_pkg::ST_LOWER_PERM;
    end else if (item.want_open == is_open) begin
      // Same state: raise to the higher priority, or drop to lowest on a close.
      wr = 1'b1;
      if (!item.want_open) begin
        ent_new.prio = pppa_pkg::PRIO_LOWEST;
      end else if (item.requester_priority > owner) begin
        ent_new.prio = item.requester_priority;
      end
    end else if (item.want_open && (open_cnt >= max_open)) begin
      status = pppa_pkg::ST_OVER_MAX;
    end else begin
      act = 1'b1;
      if (item.switch_outcome != pppa_pkg::SW_DONE &&
          item.switch_outcome != pppa_pkg::SW_REFUSED) begin
        status = pppa_pkg::ST_SW_FAILED;
      end else begin
        wr              = 1'b1;
        ent_new.is_open = item.want_open;
        if (!item.want_open) begin
          ent_new.prio = pppa_pkg::PRIO_LOWEST;
          if (item.switch_outcome == pppa_pkg::SW_DONE && open_cnt != 6'd0) begin
            cnt_next = open_cnt - 6'd1;
          end
        end else begin
          // The forcing level is not kept as owner priority.
          ent_new.prio = (item.requester_priority == pppa_pkg::PRIO_HIGHEST) ?
                         pppa_pkg::PRIO_LOWEST : item.requester_priority;
          if (item.switch_outcome == pppa_pkg::SW_DONE &&
              open_cnt != pppa_pkg::COUNT_MAX) begin
            cnt_next = open_cnt + 6'd1;
          end
        end
      end
    end
  end

  // State, open count, valid bits and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      rsp_valid <= 1'b0;
      open_cnt  <= 6'd0;
      ent_valid <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (req_acc) begin
            st <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (load) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
      if (load) begin
        rsp_valid <= 1'b1;
        open_cnt  <= cnt_next;
        if (wr) begin
          ent_valid[waddr] <= 1'b1;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_acc) begin
      item <= req_data;
    end
    if (load) begin
      rsp_data.status         <= status;
      rsp_data.actuate        <= act;
      rsp_data.port_is_open   <= ent_new.is_open;
      rsp_data.owner_priority <= ent_new.prio;
      rsp_data.open_count     <= cnt_next;
    end
  end

  `PPPA_ASSERT(a_acc_to_exec, req_acc |=> (st == S_EXEC), "accepted request did not enter decide")
  `PPPA_ASSERT(a_load_gives_rsp, load |=> rsp_valid, "decided request produced no result")
  `PPPA_ASSERT(a_we_in_exec, ram_we |-> (st == S_EXEC), "table written outside decide cycle")
  `PPPA_ASSERT(a_cnt_only_on_load, !load |=> $stable(open_cnt), "open count moved without a result")
  `PPPA_ASSERT_ALWAYS(a_rst_clears, rst |=> (!rsp_valid && st == S_IDLE), "reset left control state")

endmodule

@@ hw/rtl/pppa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pppa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ test/port_power_priority_arbiter_top_test.sv @@
// Self-checking testbench for the port power priority arbiter top level.
`timescale 1ns / 1ps

module port_power_priority_arbiter_top_test;

  localparam int PORTS = 32;

  // The switch answers that the package leaves unnamed.
  localparam logic [1:0] SW_FAILED = 2'd2;
  localparam logic [1:0] SW_UNUSED = 2'd3;

  // The only register, max_open_ports, sits at byte address zero.
  localparam logic [2:0] MAX_OPEN_ADDR = {pppa_pkg::REG_MAX_OPEN, 2'b00};

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  pppa_pkg::req_t  req_data = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  pppa_pkg::rsp_t  rsp_data;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  port_power_priority_arbiter_top #(
    .NUM_PORTS(PORTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial forever #6 clk = ~clk;

  // Our own copy of the port table, the open count and the limit register.
  logic       port_open [PORTS];
  logic [2:0] owner_prio [PORTS];
  logic [5:0] open_total;
  logic [5:0] max_open_cfg;

  pppa_pkg::req_t request_backlog [$];  // requests not yet presented to the block
  pppa_pkg::rsp_t answer_queue [$];     // answers owed for accepted requests
  int   queued_count = 0;
  int   accepted_count = 0;
  int   errors = 0;

  // Chance in percent, per cycle, that either side starts an idle burst.
  int   idle_odds = 0;
  int   send_gap = 0;
  int   hold_left = 0;

  // Works out the answer to one accepted request and applies its effect to
  // our copy of the port table.
  function automatic pppa_pkg::rsp_t arbitrate(input pppa_pkg::req_t r);
    pppa_pkg::rsp_t a;
    logic [2:0]     owner;
    logic           is_open;
    int             p;
    a = '0;
    a.status = pppa_pkg::ST_OK;
    if (r.port_index >= PORTS) begin
      // An out-of-range port reports as closed, lowest priority.
      a.status = pppa_pkg::ST_BAD_PORT;
      a.open_count = open_total;
      return a;
    end
    p = int'(r.port_index);
    owner = owner_prio[p];
    is_open = port_open[p];
    if (r.opcode == pppa_pkg::OP_REINIT) begin
      // Reinitialize counts down even when the port was already closed.
      port_open[p] = 1'b0;
      owner_prio[p] = pppa_pkg::PRIO_LOWEST;
      if (open_total != 0) open_total--;
    end else if ((r.want_open || is_open) && r.requester_priority < owner) begin
      a.status = pppa_pkg::ST_LOWER_PERM;
    end else if (r.want_open == is_open) begin
      // Asking for the state the port already has only touches the owner.
      if (r.want_open) begin
        owner_prio[p] = (owner > r.requester_priority) ? owner : r.requester_priority;
      end else begin
        owner_prio[p] = pppa_pkg::PRIO_LOWEST;
      end
    end else if (r.want_open && open_total >= max_open_cfg) begin
      a.status = pppa_pkg::ST_OVER_MAX;
    end else begin
      a.actuate = 1'b1;
      if (r.switch_outcome != pppa_pkg::SW_DONE &&
          r.switch_outcome != pppa_pkg::SW_REFUSED) begin
        a.status = pppa_pkg::ST_SW_FAILED;
      end else begin
        // A refusing switch still flips the flag, but the count stays.
        if (r.want_open) begin
          owner_prio[p] = (r.requester_priority == pppa_pkg::PRIO_HIGHEST) ?
                          pppa_pkg::PRIO_LOWEST : r.requester_priority;
          if (r.switch_outcome == pppa_pkg::SW_DONE && open_total != pppa_pkg::COUNT_MAX)
            open_total++;
        end else begin
          owner_prio[p] = pppa_pkg::PRIO_LOWEST;
          if (r.switch_outcome == pppa_pkg::SW_DONE && open_total != 0) open_total--;
        end
        port_open[p] = r.want_open;
      end
    end
    a.port_is_open = port_open[p];
    a.owner_priority = owner_prio[p];
    a.open_count = open_total;
    return a;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic queue_request(input logic op, input logic [5:0] port, input logic want,
                               input logic [2:0] prio, input logic [1:0] sw);
    pppa_pkg::req_t r;
    r.opcode = op;
    r.port_index = port;
    r.want_open = want;
    r.requester_priority = prio;
    r.switch_outcome = sw;
    request_backlog.push_back(r);
    queued_count++;
  endtask

  // Random requests aimed at a few busy ports so that owners collide, with
  // the odd reinitialize and the odd port beyond the table.
  task automatic queue_random(input int count);
    logic [5:0] port;
    logic [1:0] sw;
    int         pick;
    repeat (count) begin
      pick = int'($urandom_range(99));
      if (pick < 8) port = 6'($urandom_range(63, PORTS));
      else if (pick < 55) port = 6'($urandom_range(7));
      else port = 6'($urandom_range(PORTS - 1));
      pick = int'($urandom_range(9));
      if (pick < 5) sw = pppa_pkg::SW_DONE;
      else if (pick < 8) sw = pppa_pkg::SW_REFUSED;
      else if (pick == 8) sw = SW_FAILED;
      else sw = SW_UNUSED;
      queue_request(($urandom_range(9) == 0) ? pppa_pkg::OP_REINIT : pppa_pkg::OP_POWER,
                    port, 1'($urandom_range(1)), 3'($urandom_range(7)), sw);
    end
  endtask

  // Waits until every queued request has been taken and answered.
  task automatic settle();
    while (accepted_count != queued_count || answer_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the open-port limit, then reads it back. Called at a clock edge.
  task automatic program_max_open(input logic [5:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_OPEN_ADDR;
    pwdata <= {26'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    max_open_cfg = v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[5:0] !== v) begin
      $display("%0t ns: max_open_ports readback mismatch, expected %0d, actual %0d",
               $time, v, prdata[5:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Request driver: a transfer happens at an edge with valid high and stall
  // low. The answer is predicted right at that edge, from the same payload.
  always @(posedge clk) begin
    logic           nxt_valid;
    pppa_pkg::req_t nxt_data;
    nxt_valid = req_valid;
    nxt_data = req_data;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        answer_queue.push_back(arbitrate(req_data));
        accepted_count++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (idle_odds > 0 && $urandom_range(99) < idle_odds) begin
          send_gap = $urandom_range(8, 1) - 1;
        end else if (request_backlog.size() > 0) begin
          nxt_data = request_backlog.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    req_valid <= nxt_valid;
    req_data <= nxt_data;
  end

  // Response monitor: every answer transfer is checked against the oldest
  // prediction, and the stall line is worked in random bursts.
  always @(posedge clk) begin
    logic           nxt_stall;
    pppa_pkg::rsp_t want;
    nxt_stall = 1'b0;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (answer_queue.size() == 0) begin
          $display("%0t ns: answer with none expected, expected nothing, actual %p",
                   $time, rsp_data);
          errors++;
        end else begin
          want = answer_queue.pop_front();
          check_field("status", int'(want.status), int'(rsp_data.status));
          check_field("actuate", int'(want.actuate), int'(rsp_data.actuate));
          check_field("port_is_open", int'(want.port_is_open),
                      int'(rsp_data.port_is_open));
          check_field("owner_priority", int'(want.owner_priority),
                      int'(rsp_data.owner_priority));
          check_field("open_count", int'(want.open_count), int'(rsp_data.open_count));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (idle_odds > 0 && $urandom_range(99) < idle_odds) begin
        hold_left = $urandom_range(8, 1) - 1;
        nxt_stall = 1'b1;
      end
    end
    rsp_stall <= nxt_stall;
  end

  initial begin
    for (int i = 0; i < PORTS; i++) begin
      port_open[i] = 1'b0;
      owner_prio[i] = pppa_pkg::PRIO_LOWEST;
    end
    open_total = '0;
    max_open_cfg = pppa_pkg::MAX_OPEN_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through each rule under the reset limit.
    idle_odds = 15;
    queue_request(pppa_pkg::OP_POWER, 6'd32, 1'b1, 3'd7, pppa_pkg::SW_DONE);    // past table
    queue_request(pppa_pkg::OP_REINIT, 6'd63, 1'b0, 3'd0, SW_UNUSED);           // top port
    queue_request(pppa_pkg::OP_POWER, 6'd0, 1'b1, 3'd3, pppa_pkg::SW_DONE);     // plain open
    queue_request(pppa_pkg::OP_POWER, 6'd0, 1'b1, 3'd2, pppa_pkg::SW_DONE);     // open below
    queue_request(pppa_pkg::OP_POWER, 6'd0, 1'b0, 3'd1, pppa_pkg::SW_DONE);     // close below
    queue_request(pppa_pkg::OP_POWER, 6'd0, 1'b1, 3'd5, pppa_pkg::SW_DONE);     // owner rises
    queue_request(pppa_pkg::OP_POWER, 6'd0, 1'b0, 3'd7, pppa_pkg::SW_DONE);     // plain close
    queue_request(pppa_pkg::OP_POWER, 6'd1, 1'b1, 3'd7, pppa_pkg::SW_DONE);     // forcing level
    queue_request(pppa_pkg::OP_POWER, 6'd2, 1'b1, 3'd4, pppa_pkg::SW_REFUSED);  // refused
    queue_request(pppa_pkg::OP_POWER, 6'd3, 1'b1, 3'd6, SW_FAILED);             // switch fails
    queue_request(pppa_pkg::OP_POWER, 6'd3, 1'b1, 3'd6, SW_UNUSED);             // unused answer
    queue_request(pppa_pkg::OP_POWER, 6'd4, 1'b0, 3'd0, pppa_pkg::SW_DONE);     // already closed
    queue_request(pppa_pkg::OP_POWER, 6'd2, 1'b0, 3'd4, pppa_pkg::SW_DONE);     // close refused port
    queue_request(pppa_pkg::OP_REINIT, 6'd1, 1'b0, 3'd0, pppa_pkg::SW_DONE);    // reinit open
    queue_request(pppa_pkg::OP_REINIT, 6'd5, 1'b1, 3'd7, pppa_pkg::SW_DONE);    // count at zero
    queue_request(pppa_pkg::OP_POWER, 6'd31, 1'b1, 3'd7, pppa_pkg::SW_DONE);    // last port
    queue_request(pppa_pkg::OP_POWER, 6'd31, 1'b0, 3'd0, pppa_pkg::SW_DONE);
    queue_request(pppa_pkg::OP_POWER, 6'd6, 1'b1, 3'd0, pppa_pkg::SW_DONE);
    queue_request(pppa_pkg::OP_POWER, 6'd6, 1'b1, 3'd0, pppa_pkg::SW_REFUSED);
    queue_request(pppa_pkg::OP_POWER, 6'd6, 1'b0, 3'd0, SW_FAILED);
    settle();

    // No port may open at all.
    program_max_open(6'd0);
    queue_random(40);
    settle();

    // Top limit: open-then-refused-close on one port pumps the count up to
    // the limit without a port being left open, then the limit refuses.
    idle_odds = 0;
    program_max_open(6'd63);
    repeat (66) begin
      queue_request(pppa_pkg::OP_POWER, 6'd7, 1'b1, 3'd7, pppa_pkg::SW_DONE);
      queue_request(pppa_pkg::OP_POWER, 6'd7, 1'b0, 3'd0, pppa_pkg::SW_REFUSED);
    end
    settle();
    idle_odds = 25;
    queue_random(40);
    settle();

    // A tight limit, so that opens often run into it.
    idle_odds = 10;
    program_max_open(6'd3);
    queue_random(80);
    settle();

    idle_odds = 30;
    program_max_open(6'($urandom_range(62, 1)));
    queue_random(80);
    settle();

    // Last stretch at the reset limit without any idling.
    idle_odds = 0;
    program_max_open(pppa_pkg::MAX_OPEN_RESET);
    queue_random(60);
    settle();

    if (errors == 0) begin
      $display("port_power_priority_arbiter_top verification clean");
    end else begin
      $display("port_power_priority_arbiter_top verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("port_power_priority_arbiter_top verification failed");
    $finish;
  end

endmodule
